// ----- design/wtcc_pkg.sv -----
// ----------------------------------------------------------------------------
// wtcc_pkg
// Shared types and constants for the wheel torque command conditioner.
// ----------------------------------------------------------------------------
package wtcc_pkg;

  // Fixed field widths.
  localparam int SPEED_BITS   = 24;
  localparam int CFG_BITS     = 23;
  localparam int RATIO_BITS   = 16;
  localparam int MAG_BITS     = 24;
  localparam int CRIT_BITS    = CFG_BITS + RATIO_BITS;
  localparam int PROD_BITS    = CFG_BITS + MAG_BITS - 1;
  localparam int QUO_BITS     = 23;
  localparam int FRAC_SHIFT   = 16;
  localparam int LOW_BITS     = QUO_BITS - FRAC_SHIFT;

  // Configuration port geometry.
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;
  localparam int REG_IDX_BITS = 3;

  // Queue between front and back.
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  // Register indexes.
  localparam logic [REG_IDX_BITS-1:0] REG_TORQUE_LIMIT    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TORQUE_DEADBAND = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_FRICTION_TORQUE = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SPEED_LIMIT     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_LINEAR_RATIO    = 3'd4;

  // Friction operation chosen by the front.
  typedef enum logic [2:0] {
    OP_PASS,
    OP_SUB_FR,
    OP_ADD_FR,
    OP_SUB_Q,
    OP_ADD_Q
  } op_t;

  // Configuration register set.
  typedef struct packed {
    logic [CFG_BITS-1:0]   torque_limit;
    logic [CFG_BITS-1:0]   torque_deadband;
    logic [CFG_BITS-1:0]   friction_torque;
    logic [CFG_BITS-1:0]   speed_limit;
    logic [RATIO_BITS-1:0] linear_zone_ratio;
  } cfg_t;

  // Work handed from the front to the back.
  typedef struct packed {
    op_t                  op;
    logic [PROD_BITS-1:0] prod;
    logic [CRIT_BITS-1:0] crit;
  } job_t;

  localparam int JOB_BITS = $bits(job_t);

endpackage

// ----- design/wheel_torque_command_conditioner.sv -----
// Throughput: one word per cycle while the output does not stall; the divider is a 23-stage restoring divider.
// Stalls on the output back up through the queue without losing words.
// Reset: synchronous, active low; clears all valids and the configuration
// registers to zero. There is no clearing pass.
// ----------------------------------------------------------------------------
// wheel_torque_command_conditioner
// Clamps, deadbands and applies Coulomb friction to a wheel torque command.
// ----------------------------------------------------------------------------
module wheel_torque_command_conditioner import wtcc_pkg::*; #(
  parameter int TORQUE_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // in_tdata: torque_command, wheel_speed (lowest bits first)
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [((TORQUE_BITS+SPEED_BITS+7)/8)*8-1:0]   in_tdata,
  // out_tdata: applied_torque
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [((TORQUE_BITS+7)/8)*8-1:0]              out_tdata,
  input  logic                                          cfg_psel,
  input  logic                                          cfg_penable,
  input  logic                                          cfg_pwrite,
  input  logic [CFG_AW-1:0]                             cfg_paddr,
  input  logic [CFG_DW-1:0]                             cfg_pwdata,
  output logic [CFG_DW-1:0]                             cfg_prdata,
  output logic                                          cfg_pready
);

  localparam int OUT_W = ((TORQUE_BITS + 7) / 8) * 8;
  localparam int QW    = TORQUE_BITS + JOB_BITS;

  logic [CFG_BITS-1:0]           torque_limit_r, torque_deadband_r;
  logic [CFG_BITS-1:0]           friction_torque_r, speed_limit_r;
  logic [RATIO_BITS-1:0]         linear_zone_ratio_r;
  logic [REG_IDX_BITS-1:0]       reg_idx;
  logic                          wr_en;
  cfg_t                          cfg;

  logic signed [TORQUE_BITS-1:0] torque_command;
  logic signed [SPEED_BITS-1:0]  wheel_speed;
  logic                          f_valid, f_ready;
  logic signed [TORQUE_BITS-1:0] f_cmd;
  job_t                          f_job;
  logic                          q_valid, q_ready;
  logic [QW-1:0]                 q_data;
  logic signed [TORQUE_BITS-1:0] applied_torque;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_limit_r      <= '0;
      torque_deadband_r   <= '0;
      friction_torque_r   <= '0;
      speed_limit_r       <= '0;
      linear_zone_ratio_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TORQUE_LIMIT:    torque_limit_r      <= cfg_pwdata[CFG_BITS-1:0];
        REG_TORQUE_DEADBAND: torque_deadband_r   <= cfg_pwdata[CFG_BITS-1:0];
        REG_FRICTION_TORQUE: friction_torque_r   <= cfg_pwdata[CFG_BITS-1:0];
        REG_SPEED_LIMIT:     speed_limit_r       <= cfg_pwdata[CFG_BITS-1:0];
        REG_LINEAR_RATIO:    linear_zone_ratio_r <= cfg_pwdata[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_TORQUE_LIMIT:    cfg_prdata = CFG_DW'(torque_limit_r);
      REG_TORQUE_DEADBAND: cfg_prdata = CFG_DW'(torque_deadband_r);
      REG_FRICTION_TORQUE: cfg_prdata = CFG_DW'(friction_torque_r);
      REG_SPEED_LIMIT:     cfg_prdata = CFG_DW'(speed_limit_r);
      REG_LINEAR_RATIO:    cfg_prdata = CFG_DW'(linear_zone_ratio_r);
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.torque_limit      = torque_limit_r;
    cfg.torque_deadband   = torque_deadband_r;
    cfg.friction_torque   = friction_torque_r;
    cfg.speed_limit       = speed_limit_r;
    cfg.linear_zone_ratio = linear_zone_ratio_r;
  end

  // Input word fields.
  assign torque_command = in_tdata[TORQUE_BITS-1:0];
  assign wheel_speed    = in_tdata[TORQUE_BITS+SPEED_BITS-1:TORQUE_BITS];

  wtcc_front #(
    .TORQUE_BITS (TORQUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (torque_command),
    .in_speed  (wheel_speed),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_cmd   (f_cmd),
    .out_job   (f_job)
  );

  wtcc_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cmd, f_job}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  wtcc_back #(
    .TORQUE_BITS (TORQUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .friction   (friction_torque_r),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_cmd     (q_data[QW-1:JOB_BITS]),
    .in_job     (q_data[JOB_BITS-1:0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_torque (applied_torque)
  );

  // Result word, zero padded to whole bytes.
  assign out_tdata = OUT_W'($unsigned(applied_torque));

`ifndef NO_ASSERTIONS
  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result word pending right after reset");

  // A torque limit write lands in the register.
  a_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (reg_idx == REG_TORQUE_LIMIT) |=>
      torque_limit_r == $past(cfg_pwdata[CFG_BITS-1:0]))
    else $error("torque limit write lost");

  // A linear zone ratio write lands in the register.
  a_ratio_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (reg_idx == REG_LINEAR_RATIO) |=>
      linear_zone_ratio_r == $past(cfg_pwdata[RATIO_BITS-1:0]))
    else $error("linear zone ratio write lost");
`endif

endmodule

// ----- design/wtcc_front.sv -----
// ----------------------------------------------------------------------------
// wtcc_front
// Accepts words, clamps and deadbands the command, and classifies the
// friction case against the critical speed.
// ----------------------------------------------------------------------------
module wtcc_front import wtcc_pkg::*; #(
  parameter int TORQUE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [TORQUE_BITS-1:0] in_cmd,
  input  logic signed [SPEED_BITS-1:0]  in_speed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [TORQUE_BITS-1:0] out_cmd,
  output job_t                          out_job
);

  localparam int SW = ((TORQUE_BITS > SPEED_BITS) ? TORQUE_BITS : SPEED_BITS) + 1;

  logic                          adv;
  logic                          v1_r, v2_r, v3_r;
  logic signed [TORQUE_BITS-1:0] c1_r, c2_r, c3_r;
  logic signed [SPEED_BITS-1:0]  s1_r;
  logic                          neg2_r;
  logic [MAG_BITS-1:0]           mag2_r;
  logic [CRIT_BITS-1:0]          crit_r, crit_nxt;
  job_t                          job3_r;

  logic signed [SW-1:0]          cw, lim_w, db_w, cl_w, abs_w;
  logic signed [TORQUE_BITS-1:0] c2_nxt;
  logic [MAG_BITS-1:0]           mag2_nxt;
  logic [CRIT_BITS:0]            mag28, crit_ext;
  op_t                           op_nxt;
  logic [PROD_BITS-1:0]          prod_nxt;

  // The whole front moves when its last stage is empty or drained.
  assign adv      = !v3_r || out_ready;
  assign in_ready = adv;

  // Critical speed follows the configuration.
  assign crit_nxt = CRIT_BITS'(cfg.speed_limit) * CRIT_BITS'(cfg.linear_zone_ratio);

  always_ff @(posedge clk) begin
    crit_r <= crit_nxt;
  end

  // Clamp to the torque limit, then apply the deadband.
  always_comb begin
    cw    = SW'(c1_r);
    lim_w = $signed({{(SW-CFG_BITS){1'b0}}, cfg.torque_limit});
    db_w  = $signed({{(SW-CFG_BITS){1'b0}}, cfg.torque_deadband});
    cl_w  = cw;
    if (lim_w != '0) begin
      if (cw > lim_w) begin
        cl_w = lim_w;
      end else if (cw < -lim_w) begin
        cl_w = -lim_w;
      end
    end
    abs_w  = (cl_w < 0) ? -cl_w : cl_w;
    c2_nxt = (abs_w < db_w) ? '0 : cl_w[TORQUE_BITS-1:0];
  end

  // Speed magnitude; the most negative speed maps to 2^23.
  assign mag2_nxt = s1_r[SPEED_BITS-1] ? MAG_BITS'(-s1_r) : MAG_BITS'(s1_r);

  // Friction case against the critical speed, and the divider's numerator.
  always_comb begin
    mag28    = {mag2_r, {FRAC_SHIFT{1'b0}}};
    crit_ext = {1'b0, crit_r};
    prod_nxt = PROD_BITS'(cfg.friction_torque) * PROD_BITS'(mag2_r);
    if (mag28 > crit_ext) begin
      op_nxt = neg2_r ? OP_ADD_FR : OP_SUB_FR;
    end else if (crit_r == '0) begin
      op_nxt = OP_PASS;
    end else begin
      op_nxt = neg2_r ? OP_ADD_Q : OP_SUB_Q;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r        <= in_cmd;
      s1_r        <= in_speed;
      c2_r        <= c2_nxt;
      neg2_r      <= s1_r[SPEED_BITS-1];
      mag2_r      <= mag2_nxt;
      c3_r        <= c2_r;
      job3_r.op   <= op_nxt;
      job3_r.prod <= prod_nxt;
      job3_r.crit <= crit_r;
    end
  end

  assign out_valid = v3_r;
  assign out_cmd   = c3_r;
  assign out_job   = job3_r;

endmodule

// ----- design/wtcc_fifo.sv -----
// ----------------------------------------------------------------------------
// wtcc_fifo
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module wtcc_fifo import wtcc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    cnt_r;
  logic             push, pop;

  assign in_ready  = (cnt_r != Q_DEPTH[Q_AW:0]);
  assign out_valid = (cnt_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ----- design/wtcc_back.sv -----
// ----------------------------------------------------------------------------
// wtcc_back
// Pipelined restoring divider for the linear friction zone, followed by the
// final add, saturation and the output register.
// ----------------------------------------------------------------------------
module wtcc_back import wtcc_pkg::*; #(
  parameter int TORQUE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CFG_BITS-1:0]           friction,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [TORQUE_BITS-1:0] in_cmd,
  input  job_t                          in_job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [TORQUE_BITS-1:0] out_torque
);

  localparam int SW = ((TORQUE_BITS > SPEED_BITS) ? TORQUE_BITS : SPEED_BITS) + 1;
  localparam int N  = QUO_BITS;

  logic                          adv;
  logic [N:0]                    dv_r;
  logic [CRIT_BITS-1:0]          rem_r  [N+1];
  logic [CRIT_BITS-1:0]          crit_r [N+1];
  logic [QUO_BITS-1:0]           lq_r   [N+1];
  op_t                           op_r   [N+1];
  logic signed [TORQUE_BITS-1:0] cmd_r  [N+1];

  logic [CRIT_BITS:0]            trial  [N];
  logic [CRIT_BITS:0]            diff   [N];
  logic                          ge     [N];

  logic                          ov_r;
  logic signed [TORQUE_BITS-1:0] torque_r;
  logic signed [SW-1:0]          cmd_w, fr_w, q_w, sum, tmax, tmin;
  logic signed [TORQUE_BITS-1:0] torque_nxt;

  assign adv      = !ov_r || out_ready;
  assign in_ready = adv;

  // One quotient bit per stage.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      trial[k] = {rem_r[k], lq_r[k][QUO_BITS-1]};
      diff[k]  = trial[k] - {1'b0, crit_r[k]};
      ge[k]    = (trial[k] >= {1'b0, crit_r[k]});
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= {dv_r[N-1:0], in_valid};
    end
  end

  // Divider payload: the remainder starts from the numerator's upper bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= in_job.prod[PROD_BITS-1:LOW_BITS];
      lq_r[0]   <= {in_job.prod[LOW_BITS-1:0], {FRAC_SHIFT{1'b0}}};
      crit_r[0] <= in_job.crit;
      op_r[0]   <= in_job.op;
      cmd_r[0]  <= in_cmd;
      for (int k = 0; k < N; k++) begin
        rem_r[k+1]  <= ge[k] ? diff[k][CRIT_BITS-1:0] : trial[k][CRIT_BITS-1:0];
        lq_r[k+1]   <= {lq_r[k][QUO_BITS-2:0], ge[k]};
        crit_r[k+1] <= crit_r[k];
        op_r[k+1]   <= op_r[k];
        cmd_r[k+1]  <= cmd_r[k];
      end
    end
  end

  // Apply friction and saturate.
  always_comb begin
    tmax  = $signed({{(SW-TORQUE_BITS+1){1'b0}}, {(TORQUE_BITS-1){1'b1}}});
    tmin  = ~tmax;
    cmd_w = SW'(cmd_r[N]);
    fr_w  = $signed({{(SW-CFG_BITS){1'b0}}, friction});
    q_w   = $signed({{(SW-QUO_BITS){1'b0}}, lq_r[N]});
    unique case (op_r[N])
      OP_SUB_FR: sum = cmd_w - fr_w;
      OP_ADD_FR: sum = cmd_w + fr_w;
      OP_SUB_Q:  sum = cmd_w - q_w;
      OP_ADD_Q:  sum = cmd_w + q_w;
      default:   sum = cmd_w;
    endcase
    if (sum > tmax) begin
      torque_nxt = tmax[TORQUE_BITS-1:0];
    end else if (sum < tmin) begin
      torque_nxt = tmin[TORQUE_BITS-1:0];
    end else begin
      torque_nxt = sum[TORQUE_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      torque_r <= torque_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_torque = torque_r;

endmodule

// ----- sim/tb_wheel_torque_command_conditioner.sv -----
// ----------------------------------------------------------------------------
// tb_wheel_torque_command_conditioner
// Self-checking bench for the wheel torque command conditioner. A table of
// directed words covers reset behavior, the field extremes, clamping, the
// deadband, the linear friction zone and its bounds, saturation and a zero
// critical speed. Randomized phases follow, each with its own register
// setting, and use commands and speeds aimed at the limits and the zone edges.
// Every result word is compared with a local model of the arithmetic, or with
// a pinned row's expectation, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_wheel_torque_command_conditioner;
  import wtcc_pkg::*;

  localparam int TB_TW = 24;
  localparam int IN_W  = ((TB_TW + SPEED_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((TB_TW + 7) / 8) * 8;

  // Run shape.
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 142;
  localparam int SETTLE_CYCLES   = 40;
  localparam int END_WAIT        = 20000;
  localparam int MAX_REPORTS     = 30;
  // Slowest correct run: about 1720 words, each with the longest send gap and
  // the longest output stall, plus the drains between phases.
  localparam int LIMIT_CYCLES    = 1000000;

  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_FIRST = REG_LINEAR_RATIO + 1'b1;
  localparam int N_UNUSED = (1 << REG_IDX_BITS) - int'(REG_UNUSED_FIRST);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Typed-in expectation that travels with the word being offered.
  logic              in_pin_valid = 1'b0;
  logic [OUT_W-1:0]  in_pin_value = '0;

  cfg_t             shadow_cfg = '0;
  logic [OUT_W-1:0] applied_q [$];
  int               mismatches = 0;
  int               words_in = 0;
  int               settings_used = 0;
  int               cycle_count = 0;
  int               tx_quiet = 0;
  int               rx_quiet = 0;
  int               rx_stall = 0;

  wheel_torque_command_conditioner #(
    .TORQUE_BITS(TB_TW)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Directed stimulus. cfg_sel picks a setting from dir_cfgs (0 keeps the
  // current one); pinned rows carry an expectation typed in by hand.
  typedef struct packed {
    logic [2:0]            cfg_sel;
    logic [TB_TW-1:0]      cmd;
    logic [SPEED_BITS-1:0] spd;
    logic                  pinned;
    logic [TB_TW-1:0]      want;
  } stim_row_t;

  cfg_t dir_cfgs [4] = '{
    // Moderate limits with a linear zone of +/- 0x800 in speed.
    '{23'h100000, 23'h010000, 23'h008000, 23'h001000, 16'h8000},
    // Full friction, no clamp, no deadband, zone disabled.
    '{23'h000000, 23'h000000, 23'h7FFFFF, 23'h000000, 16'h0000},
    // Zone enabled but zero critical speed, widest deadband.
    '{23'h7FFFFF, 23'h7FFFFF, 23'h400000, 23'h000000, 16'hFFFF},
    // Every register at its top value but the deadband, which is zero.
    '{23'h7FFFFF, 23'h000000, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF}
  };

  stim_row_t stim_rows [22] = '{
    '{3'd0, 24'h7FFFFF, 24'h000000, 1'b1, 24'h7FFFFF},
    '{3'd0, 24'h800000, 24'h7FFFFF, 1'b1, 24'h800000},
    '{3'd0, 24'h000000, 24'h800000, 1'b1, 24'h000000},
    // Clamp then subtract or add friction outside the zone.
    '{3'd1, 24'h7FFFFF, 24'h100000, 1'b1, 24'h0F8000},
    '{3'd0, 24'h800000, 24'hF00000, 1'b1, 24'hF08000},
    // Just under the deadband is zeroed; exactly at it is kept.
    '{3'd0, 24'h00FFFF, 24'h100000, 1'b1, 24'hFF8000},
    '{3'd0, 24'h010000, 24'h000000, 1'b1, 24'h010000},
    // Zone bounds (included), mid zone and one step beyond.
    '{3'd0, 24'h020000, 24'h000800, 1'b0, 24'h000000},
    '{3'd0, 24'h020000, 24'h000400, 1'b0, 24'h000000},
    '{3'd0, 24'h020000, 24'hFFF800, 1'b0, 24'h000000},
    '{3'd0, 24'h020000, 24'h000801, 1'b0, 24'h000000},
    '{3'd0, 24'hFF0001, 24'hFFFFFD, 1'b0, 24'h000000},
    // Saturation at both ends; zero speed gets no friction.
    '{3'd2, 24'h800000, 24'h000001, 1'b1, 24'h800000},
    '{3'd0, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 24'h7FFFFF},
    '{3'd0, 24'h123456, 24'h000000, 1'b1, 24'h123456},
    // Zero critical speed: zero speed lands in the zone without a divide; other speeds get full friction.
    '{3'd3, 24'h7FFFFF, 24'h000000, 1'b1, 24'h7FFFFF},
    '{3'd0, 24'h800000, 24'h000000, 1'b1, 24'h800001},
    '{3'd0, 24'h7FFFFE, 24'h000001, 1'b1, 24'hC00000},
    // Widest zone and largest products.
    '{3'd4, 24'h000000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{3'd0, 24'h7FFFFF, 24'h7FFF00, 1'b0, 24'h000000},
    '{3'd0, 24'h800000, 24'h800100, 1'b0, 24'h000000},
    '{3'd0, 24'h555555, 24'h800000, 1'b0, 24'h000000}
  };

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run-time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d words outstanding.",
               cycle_count, applied_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [CFG_DW-1:0] got,
                                 input logic [CFG_DW-1:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch at cycle %0d: %s, got %h, expected %h",
               cycle_count, what, got, want);
    end
  endtask

  // Applied torque for one command and speed under the shadow registers.
  function automatic logic [TB_TW-1:0] conditioned_torque(logic [TB_TW-1:0] cmd_bits,
                                                          logic [SPEED_BITS-1:0] spd_bits);
    longint cmd, spd, lim, fr, ratio, crit, spd28, mag, quo, res, tmax, tmin;
    cmd   = $signed(cmd_bits);
    spd   = $signed(spd_bits);
    lim   = longint'(shadow_cfg.torque_limit);
    fr    = longint'(shadow_cfg.friction_torque);
    ratio = longint'(shadow_cfg.linear_zone_ratio);
    tmax  = (longint'(1) <<< (TB_TW - 1)) - 1;
    tmin  = -tmax - 1;
    // Clamp, then deadband.
    if (lim != 0) begin
      if (cmd > lim) cmd = lim;
      else if (cmd < -lim) cmd = -lim;
    end
    if ((cmd < 0 ? -cmd : cmd) < longint'(shadow_cfg.torque_deadband)) cmd = 0;
    // Friction against the spin, linear inside the critical band.
    crit  = (ratio != 0) ? longint'(shadow_cfg.speed_limit) * ratio : 0;
    spd28 = spd * 65536;
    if (spd28 > crit) begin
      res = cmd - fr;
    end else if (spd28 < -crit) begin
      res = cmd + fr;
    end else if (ratio != 0 && crit != 0) begin
      mag = (spd28 < 0) ? -spd28 : spd28;
      quo = (fr * mag) / crit;
      res = (spd28 < 0) ? cmd + quo : cmd - quo;
    end else begin
      res = cmd;
    end
    if (res > tmax) res = tmax;
    else if (res < tmin) res = tmin;
    return res[TB_TW-1:0];
  endfunction

  // Input and output monitor: predict on acceptance, check on delivery.
  always @(posedge clk) begin : monitor
    logic [OUT_W-1:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = in_pin_valid ? in_pin_value
             : OUT_W'(conditioned_torque(in_tdata[TB_TW-1:0], in_tdata[TB_TW +: SPEED_BITS]));
        applied_q = {applied_q, want};
        words_in++;
      end
      if (out_tvalid && out_tready) begin
        if (applied_q.size() == 0) begin
          report_mismatch("result word with nothing expected", CFG_DW'(out_tdata), '0);
        end else begin
          want = applied_q.pop_front();
          if (out_tdata !== want) begin
            report_mismatch("applied_torque", CFG_DW'(out_tdata), CFG_DW'(want));
          end
        end
      end
    end
  end

  // Output back-pressure: short and long stalls, with stall-free stretches.
  always @(posedge clk) begin : rx_pressure
    int r;
    r = $urandom_range(0, 99);
    if (rx_quiet != 0) begin
      rx_quiet = rx_quiet - 1;
      out_tready <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall = rx_stall - 1;
      out_tready <= 1'b0;
    end else if (r < 3) begin
      rx_quiet = $urandom_range(30, 80);
      out_tready <= 1'b1;
    end else if (r < 18) begin
      rx_stall = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else if (r < 20) begin
      rx_stall = $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Idle cycles before the next input word.
  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet != 0) begin
      tx_quiet = tx_quiet - 1;
      return 0;
    end
    if (r < 2) begin
      tx_quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word and hold it until accepted. tvalid stays high when the
  // next word follows with no gap.
  task automatic send_word(input logic [TB_TW-1:0] cmd, input logic [SPEED_BITS-1:0] spd,
                           input logic pinned, input logic [TB_TW-1:0] want);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= IN_W'({spd, cmd});
    in_pin_valid <= pinned;
    in_pin_value <= OUT_W'(want);
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected word has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (applied_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer; the caller returns the bus to idle after the last one.
  task automatic apb_transfer(input logic [CFG_AW-1:0] addr, input logic wr,
                              input logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  function automatic logic [CFG_DW-1:0] reg_value(cfg_t c, logic [REG_IDX_BITS-1:0] idx);
    case (idx)
      REG_TORQUE_LIMIT:    return CFG_DW'(c.torque_limit);
      REG_TORQUE_DEADBAND: return CFG_DW'(c.torque_deadband);
      REG_FRICTION_TORQUE: return CFG_DW'(c.friction_torque);
      REG_SPEED_LIMIT:     return CFG_DW'(c.speed_limit);
      REG_LINEAR_RATIO:    return CFG_DW'(c.linear_zone_ratio);
      default:             return '0;
    endcase
  endfunction

  // Write all registers with junk above their width, poke an unused index,
  // then read each register back. Only called while the block is idle.
  task automatic program_config(input cfg_t c);
    logic [REG_IDX_BITS-1:0] idx;
    logic [CFG_DW-1:0]       junk, mask, rd;
    for (int i = 0; i <= int'(REG_LINEAR_RATIO); i++) begin
      idx  = REG_IDX_BITS'(i);
      mask = (idx == REG_LINEAR_RATIO) ? CFG_DW'((1 << RATIO_BITS) - 1)
                                       : CFG_DW'((1 << CFG_BITS) - 1);
      junk = $urandom;
      apb_transfer({idx, 2'b00}, 1'b1, reg_value(c, idx) | (junk & ~mask), rd);
    end
    idx  = REG_UNUSED_FIRST + REG_IDX_BITS'($urandom_range(0, N_UNUSED - 1));
    junk = $urandom;
    apb_transfer({idx, 2'b00}, 1'b1, junk, rd);
    shadow_cfg = c;
    for (int i = 0; i <= int'(REG_LINEAR_RATIO); i++) begin
      idx = REG_IDX_BITS'(i);
      apb_transfer({idx, 2'b00}, 1'b0, '0, rd);
      if (rd !== reg_value(c, idx)) report_mismatch("register readback", rd, reg_value(c, idx));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CFG_BITS-1:0] rand_mag();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return r[CFG_BITS-1:0] >> $urandom_range(0, CFG_BITS - 1);
    endcase
  endfunction

  // First random phase uses every top value, the second all zeros.
  function automatic cfg_t rand_cfg(int phase);
    cfg_t        c;
    logic [31:0] r;
    if (phase == 0) return '{'1, '1, '1, '1, '1};
    if (phase == 1) return '0;
    r = $urandom;
    c.torque_limit    = rand_mag();
    c.torque_deadband = rand_mag();
    c.friction_torque = rand_mag();
    c.speed_limit     = rand_mag();
    case ($urandom_range(0, 5))
      0:       c.linear_zone_ratio = '0;
      1:       c.linear_zone_ratio = '1;
      default: c.linear_zone_ratio = r[RATIO_BITS-1:0] >> $urandom_range(0, RATIO_BITS - 1);
    endcase
    return c;
  endfunction

  // Commands: half uniform, the rest near the clamp and deadband edges or at the extremes.
  function automatic logic [TB_TW-1:0] pick_command();
    logic [31:0] r;
    longint      v;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: return r[TB_TW-1:0];
      3:       v = longint'(shadow_cfg.torque_limit) + longint'($urandom_range(0, 4)) - 2;
      4:       v = longint'(shadow_cfg.torque_deadband) + longint'($urandom_range(0, 4)) - 2;
      default: begin
        case (r[1:0])
          2'd0:    v = (longint'(1) <<< (TB_TW - 1)) - 1;
          2'd1:    v = -(longint'(1) <<< (TB_TW - 1));
          2'd2:    v = 0;
          default: v = -1;
        endcase
        return v[TB_TW-1:0];
      end
    endcase
    if (r[31]) v = -v;
    return v[TB_TW-1:0];
  endfunction

  // Speeds: uniform, inside the linear zone, at its bounds, or near zero.
  function automatic logic [SPEED_BITS-1:0] pick_speed();
    logic [31:0] r;
    longint      bw, v;
    r  = $urandom;
    bw = (longint'(shadow_cfg.speed_limit) * longint'(shadow_cfg.linear_zone_ratio)) >>> 16;
    case ($urandom_range(0, 7))
      0, 1, 2: return r[SPEED_BITS-1:0];
      3, 4, 5: v = (bw == 0) ? 0 : longint'($urandom_range(0, 32'(2 * bw))) - bw;
      6: begin
        v = bw + longint'($urandom_range(0, 2)) - 1;
        if (r[31]) v = -v;
      end
      default: v = longint'($urandom_range(0, 32)) - 16;
    endcase
    return v[SPEED_BITS-1:0];
  endfunction

  // Stimulus sequence.
  initial begin
    int wait_n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].cfg_sel != 0) begin
        drain_results();
        program_config(dir_cfgs[stim_rows[i].cfg_sel - 1]);
      end
      send_word(stim_rows[i].cmd, stim_rows[i].spd, stim_rows[i].pinned, stim_rows[i].want);
    end

    // Random phases, each under a fresh register setting.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_results();
      program_config(rand_cfg(phase));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_word(pick_command(), pick_speed(), 1'b0, '0);
        // Hold the sender mid-phase until the pipeline has emptied.
        if (phase == 3 && k == ITEMS_PER_PHASE / 2) drain_results();
      end
    end

    // Let the pipeline empty, with a bound, then look for stray words.
    in_tvalid <= 1'b0;
    @(posedge clk);
    for (wait_n = 0; applied_q.size() != 0 && wait_n < END_WAIT; wait_n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (applied_q.size() != 0) begin
      report_mismatch("expected words never delivered", CFG_DW'(applied_q.size()), '0);
    end

    $display("Checked %0d words (%0d directed) under %0d register settings in %0d cycles.",
             words_in, $size(stim_rows), settings_used, cycle_count);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
